@@ rtl/window_overlay_raster_top_defines.svh @@
// Assertion macros shared by the window overlay raster RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WINDOW_OVERLAY_RASTER_TOP_DEFINES_SVH
`define WINDOW_OVERLAY_RASTER_TOP_DEFINES_SVH

// Clocked property that is switched off while reset is high.
`define WOR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define WOR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `WOR_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

@@ rtl/wor_pkg.sv @@
// Shared constants, register codes and item types of the window overlay raster.
// No dependencies; every RTL module imports this package.
package wor_pkg;

   localparam int MAX_WINDOWS    = 16;
   localparam int COORD_BITS     = 12;
   localparam int CHAR_BITS      = 8;
   localparam int INDEX_BITS     = 4;
   localparam int COUNT_BITS     = 5;
   localparam int CELL_IDX_BITS  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 8;

   // Register reset values.
   localparam logic [COORD_BITS-1:0] X_LOW_RESET  = COORD_BITS'(0);
   localparam logic [COORD_BITS-1:0] X_HIGH_RESET = COORD_BITS'(79);
   localparam logic [COORD_BITS-1:0] Y_LOW_RESET  = COORD_BITS'(0);
   localparam logic [COORD_BITS-1:0] Y_HIGH_RESET = COORD_BITS'(23);
   localparam logic [CHAR_BITS-1:0]  BG_RESET     = CHAR_BITS'(32);
   localparam logic [COUNT_BITS-1:0] COUNT_RESET  = COUNT_BITS'(0);

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_X_LOW  = 3'd0,
      REG_X_HIGH = 3'd1,
      REG_Y_LOW  = 3'd2,
      REG_Y_HIGH = 3'd3,
      REG_BG     = 3'd4,
      REG_COUNT  = 3'd5
   } wor_reg_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      coord_type             x_low;
      coord_type             x_high;
      coord_type             y_low;
      coord_type             y_high;
      logic [CHAR_BITS-1:0]  bg;
      logic [COUNT_BITS-1:0] count;
   } wor_cfg_type;

   // One window table entry.
   typedef struct packed {
      coord_type            xl;
      coord_type            yl;
      coord_type            xh;
      coord_type            yh;
      logic [CHAR_BITS-1:0] ch;
   } wor_win_type;

   // An item as it moves down the chain of cells.
   typedef struct packed {
      logic                  is_pixel;
      logic [INDEX_BITS-1:0] window_index;
      wor_win_type           win;
      coord_type             col;
      coord_type             row;
      logic [CHAR_BITS-1:0]  pix;
      logic                  line_end;
      logic                  frame_end;
   } wor_tok_type;

endpackage

@@ rtl/wor_csr.sv @@
// Configuration register file of the window overlay raster, APB-style write and read.
// Depends on wor_pkg.
module wor_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wor_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [wor_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [wor_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready,
   output wor_pkg::wor_cfg_type                  cfg,
   output logic                                  restart
);
   import wor_pkg::*;

   wor_cfg_type cfg_ff, cfg_in;
   logic        restart_ff, restart_in;
   logic        wr_en;
   wor_reg_type reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = wor_reg_type'(csr_paddr[4:2]);

   // Register writes; any display corner write restarts the raster.
   always_comb begin
      cfg_in     = cfg_ff;
      restart_in = 1'b0;
      if (wr_en) begin
         case (reg_sel)
            REG_X_LOW: begin
               cfg_in.x_low = csr_pwdata[COORD_BITS-1:0];
               restart_in   = 1'b1;
            end
            REG_X_HIGH: begin
               cfg_in.x_high = csr_pwdata[COORD_BITS-1:0];
               restart_in    = 1'b1;
            end
            REG_Y_LOW: begin
               cfg_in.y_low = csr_pwdata[COORD_BITS-1:0];
               restart_in   = 1'b1;
            end
            REG_Y_HIGH: begin
               cfg_in.y_high = csr_pwdata[COORD_BITS-1:0];
               restart_in    = 1'b1;
            end
            REG_BG:    cfg_in.bg    = csr_pwdata[CHAR_BITS-1:0];
            REG_COUNT: cfg_in.count = csr_pwdata[COUNT_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_low  <= X_LOW_RESET;
         cfg_ff.x_high <= X_HIGH_RESET;
         cfg_ff.y_low  <= Y_LOW_RESET;
         cfg_ff.y_high <= Y_HIGH_RESET;
         cfg_ff.bg     <= BG_RESET;
         cfg_ff.count  <= COUNT_RESET;
         restart_ff    <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         restart_ff <= restart_in;
      end
   end

   // Read-back mux.
   always_comb begin
      csr_prdata = '0;
      case (reg_sel)
         REG_X_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.x_low);
         REG_X_HIGH: csr_prdata = CSR_DATA_BITS'(cfg_ff.x_high);
         REG_Y_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.y_low);
         REG_Y_HIGH: csr_prdata = CSR_DATA_BITS'(cfg_ff.y_high);
         REG_BG:     csr_prdata = CSR_DATA_BITS'(cfg_ff.bg);
         REG_COUNT:  csr_prdata = CSR_DATA_BITS'(cfg_ff.count);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
   assign restart    = restart_ff;

endmodule

@@ rtl/wor_raster.sv @@
// Raster position counters: column and row of the next pixel and its end-of-line and end-of-frame flags.
// Depends on wor_pkg.
module wor_raster (
   input  logic                 clock,
   input  logic                 reset,
   input  wor_pkg::wor_cfg_type cfg,
   input  logic                 restart,
   input  logic                 pixel_accept,
   output wor_pkg::coord_type   col,
   output wor_pkg::coord_type   row,
   output logic                 line_end,
   output logic                 frame_end
);
   import wor_pkg::*;

   coord_type col_ff, col_in;
   coord_type row_ff, row_in;
   coord_type cur_col, cur_row;
   logic      le, fe;

   // A pending restart replaces the stored position with the display corner.
   always_comb begin
      cur_col = restart ? cfg.x_low : col_ff;
      cur_row = restart ? cfg.y_low : row_ff;
      le      = (cur_col == cfg.x_high);
      fe      = le && (cur_row == cfg.y_high);
   end

   // Step in raster order when a pixel item is taken; wrap to x_low at line end, y_low at frame end.
   always_comb begin
      col_in = cur_col;
      row_in = cur_row;
      if (pixel_accept) begin
         if (!le) begin
            col_in = cur_col + COORD_BITS'(1);
         end else begin
            col_in = cfg.x_low;
            row_in = fe ? cfg.y_low : cur_row + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= X_LOW_RESET;
         row_ff <= Y_LOW_RESET;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col       = cur_col;
   assign row       = cur_row;
   assign line_end  = le;
   assign frame_end = fe;

endmodule

@@ rtl/wor_cell.sv @@
// One cell of the window chain: holds one table entry, takes loads addressed to it,
// and paints passing pixel items it covers. Depends on wor_pkg.
module wor_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [wor_pkg::CELL_IDX_BITS-1:0]   cell_idx,
   input  logic [wor_pkg::COUNT_BITS-1:0]      window_count,
   input  logic                                in_valid,
   input  wor_pkg::wor_tok_type                in_tok,
   output logic                                out_valid,
   output wor_pkg::wor_tok_type                out_tok
);
   import wor_pkg::*;

   wor_win_type ent_ff, ent_in;
   wor_tok_type tok_ff, tok_in;
   logic        valid_ff, valid_in;
   logic        hit, active, wr;

   // Cover test and entry write decode.
   always_comb begin
      hit = (in_tok.col >= ent_ff.xl) && (in_tok.col <= ent_ff.xh) &&
            (in_tok.row >= ent_ff.yl) && (in_tok.row <= ent_ff.yh);
      active = (32'(cell_idx) < 32'(window_count));
      wr = advance && in_valid && !in_tok.is_pixel &&
           (32'(in_tok.window_index) == 32'(cell_idx));
   end

   // Later cells paint over earlier ones, so an active covering cell overrides the char.
   always_comb begin
      tok_in   = tok_ff;
      valid_in = valid_ff;
      ent_in   = wr ? in_tok.win : ent_ff;
      if (advance) begin
         valid_in = in_valid;
         tok_in   = in_tok;
         if (in_tok.is_pixel && active && hit) begin
            tok_in.pix = ent_ff.ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      ent_ff <= ent_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

@@ rtl/window_overlay_raster_top.sv @@
// Top level of the window overlay raster: register file, raster counters,
// a chain of window cells and the result register. Depends on wor_pkg, wor_csr,
// wor_raster, wor_cell and window_overlay_raster_top_defines.svh.
//
// Use: items arrive on the req_ stream. tuser bit 0 is the kind: 0 loads the window
// entry named in tdata, 1 asks for the next raster pixel. Each pixel item gives one
// result item on the rsp_ stream (character in tdata, end of line in tuser, end of
// frame in tlast); a load gives none. Items enter one per cycle while the chain is not
// held, a rate set by the chain advancing one cell per clock, and move through one cell
// per window entry, MAX_WINDOWS cells in all, so a loaded entry affects every pixel item
// taken after it. A pixel item passes through each cell register and the result register
// before it reaches rsp_. When the receiver stalls with a result waiting, the whole chain
// holds and req_tready drops in the same cycle; nothing is lost. Reset empties the chain
// and the result register, restores the register defaults and puts the raster at the
// display's top-left corner; the window table is not cleared and must be loaded before
// use. The user must write registers over the csr_ port only while no item is in flight;
// the block does not enforce this. A display corner write restarts the raster.
`include "window_overlay_raster_top_defines.svh"

module window_overlay_raster_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration port.
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wor_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [wor_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [wor_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready,
   // Input stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: window_index[3:0], win_x_low[15:4], win_y_low[27:16],
   //        win_x_high[39:28], win_y_high[51:40], fill_char[59:52], zeros[63:60]
   input  logic [wor_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // tuser: kind[0]
   input  logic [0:0]                            req_tuser,
   // Result stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: pixel_char[7:0]
   output logic [wor_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // tuser: line_end[0]
   output logic [0:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);
   import wor_pkg::*;

   wor_cfg_type cfg;
   logic        restart;
   logic        advance;
   logic        pixel_accept;
   coord_type   r_col, r_row;
   logic        r_le, r_fe;
   wor_tok_type head_tok;
   logic        last_pixel;

   logic        chain_valid [MAX_WINDOWS+1];
   wor_tok_type chain_tok   [MAX_WINDOWS+1];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]      rsp_pix_ff, rsp_pix_in;
   logic                      rsp_le_ff, rsp_le_in;
   logic                      rsp_fe_ff, rsp_fe_in;

   wor_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   // The chain moves unless a finished result is waiting on a stalled receiver.
   assign advance      = !(rsp_valid_ff && !rsp_tready);
   assign req_tready   = advance;
   assign pixel_accept = req_tvalid && advance && req_tuser[0];

   wor_raster u_raster (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .restart      (restart),
      .pixel_accept (pixel_accept),
      .col          (r_col),
      .row          (r_row),
      .line_end     (r_le),
      .frame_end    (r_fe)
   );

   // Build the item that enters the first cell.
   always_comb begin
      head_tok.is_pixel     = req_tuser[0];
      head_tok.window_index = req_tdata[3:0];
      head_tok.win.xl       = req_tdata[15:4];
      head_tok.win.yl       = req_tdata[27:16];
      head_tok.win.xh       = req_tdata[39:28];
      head_tok.win.yh       = req_tdata[51:40];
      head_tok.win.ch       = req_tdata[59:52];
      head_tok.col          = r_col;
      head_tok.row          = r_row;
      head_tok.pix          = cfg.bg;
      head_tok.line_end     = r_le;
      head_tok.frame_end    = r_fe;
   end

   assign chain_valid[0] = req_tvalid;
   assign chain_tok[0]   = head_tok;

   // One cell per table entry, in painter's order.
   for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
      wor_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .cell_idx     (CELL_IDX_BITS'(i)),
         .window_count (cfg.count),
         .in_valid     (chain_valid[i]),
         .in_tok       (chain_tok[i]),
         .out_valid    (chain_valid[i+1]),
         .out_tok      (chain_tok[i+1])
      );
   end

   // A pixel item sits at the end of the chain.
   assign last_pixel = chain_valid[MAX_WINDOWS] && chain_tok[MAX_WINDOWS].is_pixel;

   // Result register: only pixel items leave the chain as results.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_le_in    = rsp_le_ff;
      rsp_fe_in    = rsp_fe_ff;
      if (advance) begin
         rsp_valid_in = last_pixel;
         rsp_pix_in   = chain_tok[MAX_WINDOWS].pix;
         rsp_le_in    = chain_tok[MAX_WINDOWS].line_end;
         rsp_fe_in    = chain_tok[MAX_WINDOWS].frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff <= rsp_pix_in;
      rsp_le_ff  <= rsp_le_in;
      rsp_fe_ff  <= rsp_fe_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pix_ff;
   assign rsp_tuser[0] = rsp_le_ff;
   assign rsp_tlast    = rsp_fe_ff;

   // An empty result register never holds back the input side.
   `WOR_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_tready, "input stalled")
   // A pixel item leaving the last cell always lands in the result register.
   `WOR_ASSERT(a_pixel_kept, clock, reset, (advance && last_pixel) |=> rsp_valid_ff, "pixel lost")
   // A frame end is always also a line end.
   `WOR_ASSERT_IMP(a_frame_line, clock, reset, rsp_valid_ff && rsp_fe_ff, rsp_le_ff, "lone frame end")

endmodule
